/* hw/rtl/ilp_pkg.sv */
// ----------------------------------------------------------------------------
// ilp_pkg - shared types and constants for the integer literal parser
// Payload structs, register indexes, parse phases and a few character helpers.
// ----------------------------------------------------------------------------
package ilp_pkg;

  localparam int unsigned MaxTokenChars = 255;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [63:0] value;
    logic [1:0]  status;
    logic [7:0]  consumed;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_MALFORMED = 2'd1,
    ST_RANGE     = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    REG_SIGNED_MODE = 2'd0,
    REG_RANGE_LOW   = 2'd1,
    REG_RANGE_HIGH  = 2'd2
  } reg_index_t;

  typedef enum logic [3:0] {
    PH_IDLE, PH_MINUS, PH_PLUS, PH_ZERO, PH_ZERO_NOBIN, PH_HEXPFX,
    PH_DIGITS, PH_BIN, PH_KEYWORD, PH_TRUE, PH_FALSE
  } phase_t;

  typedef enum logic [1:0] {
    BASE_DEC = 2'd0, BASE_OCT = 2'd1, BASE_HEX = 2'd2, BASE_BIN = 2'd3
  } base_t;

  // Character class tags computed by the front end.
  typedef struct packed {
    logic [7:0] code;
    logic       eot;
    logic       ws;
    logic       alnum;
    logic [7:0] lower;
    logic [4:0] hexv;    // 16 when not a hex digit
  } char_info_t;

  localparam logic [63:0] SignBit = 64'h8000_0000_0000_0000;

  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd16;
    if (c >= "0" && c <= "9") r = 5'(c - "0");
    else if (c >= "a" && c <= "f") r = 5'(c - "a" + 8'd10);
    else if (c >= "A" && c <= "F") r = 5'(c - "A" + 8'd10);
    return r;
  endfunction

  function automatic logic [7:0] word_char(input logic is_true, input logic [2:0] pos);
    logic [7:0] r;
    r = 8'd0;
    if (is_true) begin
      case (pos)
        3'd0: r = "t";
        3'd1: r = "r";
        3'd2: r = "u";
        3'd3: r = "e";
        default: r = 8'd0;
      endcase
    end else begin
      case (pos)
        3'd0: r = "f";
        3'd1: r = "a";
        3'd2: r = "l";
        3'd3: r = "s";
        3'd4: r = "e";
        default: r = 8'd0;
      endcase
    end
    return r;
  endfunction

endpackage

/* hw/rtl/ilp_front.sv */
// ----------------------------------------------------------------------------
// ilp_front - character intake and classification
// Accepts a character and pushes its class tags into the queue.
// ----------------------------------------------------------------------------
module ilp_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  ilp_pkg::in_item_t  in_item,
  output logic               in_stall,
  output logic               push,
  output ilp_pkg::char_info_t push_info,
  input  logic               full
);
  import ilp_pkg::*;

  logic       valid;
  char_info_t info;
  logic       take;
  logic [7:0] c;

  assign c = in_item.char_code;
  // Hold the staged character until the queue takes it.
  assign in_stall = valid && full;
  assign take     = in_valid && !in_stall;
  assign push      = valid && !full;
  assign push_info = info;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (take) begin
      valid <= 1'b1;
    end else if (push) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      info.code  <= c;
      info.eot   <= in_item.end_of_text;
      info.ws    <= (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
      info.alnum <= (c >= "0" && c <= "9") || (c >= "a" && c <= "z") ||
                    (c >= "A" && c <= "Z");
      info.lower <= (c >= "A" && c <= "Z") ? c + 8'd32 : c;
      info.hexv  <= hex_val(c);
    end
  end
endmodule

/* hw/rtl/ilp_queue.sv */
// ----------------------------------------------------------------------------
// ilp_queue - small queue between the front and back ends
// Four-entry FIFO of classified characters.
// ----------------------------------------------------------------------------
module ilp_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  ilp_pkg::char_info_t push_info,
  output logic                full,
  input  logic                pop,
  output logic                not_empty,
  output ilp_pkg::char_info_t head
);
  import ilp_pkg::*;

  char_info_t slots [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;

  assign full      = count == 3'd4;
  assign not_empty = count != 3'd0;
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 2'd1;
      if (pop) rd_ptr <= rd_ptr + 2'd1;
      count <= count + 3'(push) - 3'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_info;
  end
endmodule

/* hw/rtl/ilp_back.sv */
// ----------------------------------------------------------------------------
// ilp_back - token parser and result register
// Steps one queued character a cycle unless the output stalls; holds results.
// ----------------------------------------------------------------------------
module ilp_back #(
  parameter int unsigned MAX_TOKEN_CHARS = ilp_pkg::MaxTokenChars
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                not_empty,
  input  ilp_pkg::char_info_t head,
  output logic                pop,
  input  logic                signed_mode,
  input  logic [63:0]         range_low,
  input  logic [63:0]         range_high,
  output logic                out_valid,
  output ilp_pkg::out_item_t  out_item,
  input  logic                out_stall
);
  import ilp_pkg::*;

  localparam int unsigned CapInt = (MAX_TOKEN_CHARS < 255) ? MAX_TOKEN_CHARS : 255;
  localparam logic [7:0] Cap = 8'(CapInt);

  phase_t      phase, phase_next;
  logic [63:0] acc, acc_next;
  base_t       base, base_next;
  logic        neg, neg_next;
  logic        ovf, ovf_next;
  logic [6:0]  bits, bits_next;
  logic [2:0]  kpos, kpos_next;
  logic [7:0]  count, count_next;

  logic        emit;
  logic [63:0] e_val;
  logic [1:0]  e_st;
  logic [7:0]  e_cnt;

  logic [7:0]  c;
  logic        step;
  logic [4:0]  radix;
  logic [63:0] acc_mul;
  logic [63:0] acc_sum;
  logic        mul_ovf;
  logic [67:0] wide;

  assign c    = head.code;
  // Take a character whenever the result register is free or draining.
  assign step = not_empty && (!out_valid || !out_stall);
  assign pop  = step;

  assign radix = (base == BASE_OCT) ? 5'd8 : (base == BASE_HEX) ? 5'd16 : 5'd10;
  always_comb begin
    case (base)
      BASE_OCT: wide = {1'b0, acc, 3'b0};
      BASE_HEX: wide = {acc, 4'b0};
      default:  wide = {1'b0, acc, 3'b0} + {3'b0, acc, 1'b0};
    endcase
  end
  assign acc_mul = wide[63:0];
  assign acc_sum = acc_mul + {59'd0, head.hexv};
  assign mul_ovf = (wide[67:64] != 4'd0) || (acc_sum < acc_mul);

  function automatic logic s_le(input logic [63:0] a, input logic [63:0] b);
    return (a ^ SignBit) <= (b ^ SignBit);
  endfunction

  always_comb begin
    logic [63:0] v;
    logic [63:0] lim;
    logic        fin;
    logic        bad;
    logic        bump;
    v = 64'd0; lim = 64'd0; fin = 1'b0; bad = 1'b0; bump = 1'b1;
    phase_next = phase; acc_next = acc; base_next = base; neg_next = neg;
    ovf_next = ovf; bits_next = bits; kpos_next = kpos; count_next = count;
    emit = 1'b0; e_val = 64'd0; e_st = ST_OK;

    case (phase)
      PH_IDLE: begin
        if (head.ws) begin
          // whitespace only counts
        end else if (c == "-" && !signed_mode) begin
          emit = 1'b1; e_st = ST_RANGE; bump = 1'b0;
        end else if (c == "t") begin
          phase_next = PH_TRUE; kpos_next = 3'd1;
        end else if (c == "f") begin
          phase_next = PH_FALSE; kpos_next = 3'd1;
        end else if (head.lower == "m") begin
          phase_next = PH_KEYWORD; kpos_next = 3'd1;
        end else if (c == "-") begin
          phase_next = PH_MINUS; neg_next = 1'b1;
        end else if (c == "+") begin
          phase_next = PH_PLUS;
        end else if (c == "0") begin
          phase_next = PH_ZERO;
        end else if (c >= "1" && c <= "9") begin
          phase_next = PH_DIGITS; base_next = BASE_DEC; acc_next = {60'd0, c[3:0]};
        end else begin
          emit = 1'b1; e_st = ST_MALFORMED; bump = 1'b0;
        end
        if (!emit && head.eot) begin
          if (head.ws) begin
            emit = 1'b1; e_st = ST_MALFORMED;
          end else fin = 1'b1;
        end
      end
      PH_TRUE, PH_FALSE: begin
        if (kpos >= ((phase == PH_TRUE) ? 3'd4 : 3'd5) ||
            c != word_char(phase == PH_TRUE, kpos)) begin
          emit = 1'b1; e_st = ST_MALFORMED; bump = 1'b0;
        end else begin
          kpos_next = kpos + 3'd1;
          if (kpos_next == ((phase == PH_TRUE) ? 3'd4 : 3'd5)) begin
            emit = 1'b1; e_val = {63'd0, phase == PH_TRUE};
          end else if (head.eot) begin
            emit = 1'b1; e_st = ST_MALFORMED;
          end
        end
      end
      PH_KEYWORD: begin
        if (kpos == 3'd3 || kpos == 3'd5) begin
          bump = 1'b0;
          if (head.alnum) begin
            emit = 1'b1; e_st = ST_MALFORMED;
          end else fin = 1'b1;
        end else begin
          if (kpos == 3'd1 && head.lower == "a") kpos_next = 3'd2;
          else if (kpos == 3'd1 && head.lower == "i") kpos_next = 3'd4;
          else if (kpos == 3'd2 && head.lower == "x") kpos_next = 3'd3;
          else if (kpos == 3'd4 && head.lower == "n") kpos_next = 3'd5;
          else begin
            emit = 1'b1; e_st = ST_MALFORMED; bump = 1'b0;
          end
          if (!emit && head.eot) fin = 1'b1;
        end
      end
      PH_MINUS, PH_PLUS: begin
        if (c == "0") begin
          phase_next = (phase == PH_MINUS) ? PH_ZERO : PH_ZERO_NOBIN;
        end else if (c >= "1" && c <= "9") begin
          phase_next = PH_DIGITS; base_next = BASE_DEC; acc_next = {60'd0, c[3:0]};
        end else begin
          emit = 1'b1; e_st = ST_MALFORMED; bump = 1'b0;
        end
        if (!emit && head.eot) fin = 1'b1;
      end
      PH_ZERO, PH_ZERO_NOBIN: begin
        if (c == "b" && phase == PH_ZERO) begin
          phase_next = PH_BIN; base_next = BASE_BIN;
        end else if (c == "x" || c == "X") begin
          phase_next = PH_HEXPFX;
        end else if (c >= "0" && c <= "7") begin
          phase_next = PH_DIGITS; base_next = BASE_OCT; acc_next = {61'd0, c[2:0]};
        end else begin
          fin = 1'b1; bump = 1'b0;
        end
        if (!fin && head.eot) fin = 1'b1;
      end
      PH_HEXPFX: begin
        if (head.hexv[4]) begin
          emit = 1'b1; e_st = ST_MALFORMED; bump = 1'b0;
        end else begin
          phase_next = PH_DIGITS; base_next = BASE_HEX; acc_next = {60'd0, head.hexv[3:0]};
          if (head.eot) fin = 1'b1;
        end
      end
      PH_DIGITS: begin
        if (head.hexv >= radix) begin
          fin = 1'b1; bump = 1'b0;
        end else begin
          if (!ovf) begin
            if (mul_ovf) ovf_next = 1'b1;
            else acc_next = acc_sum;
          end
          if (head.eot) fin = 1'b1;
        end
      end
      PH_BIN: begin
        if (c == "0") begin
          if (bits != 7'd0) begin
            acc_next = {acc[62:0], 1'b0}; bits_next = bits + 7'd1;
          end
        end else if (c == "1") begin
          acc_next = {acc[62:0], 1'b1}; bits_next = bits + 7'd1;
        end else begin
          fin = 1'b1; bump = 1'b0;
        end
        if (!fin) begin
          if (bits_next > (signed_mode ? 7'd63 : 7'd64)) begin
            emit = 1'b1; e_st = ST_RANGE; bump = 1'b0;
          end else if (head.eot) fin = 1'b1;
        end
      end
      default: begin
        bump = 1'b0;
        phase_next = PH_IDLE;
      end
    endcase

    if (bump && count_next < Cap) count_next = count + 8'd1;
    e_cnt = count_next;

    // Close the token using the state as updated by this character.
    if (fin) begin
      emit = 1'b1;
      case (phase_next)
        PH_ZERO, PH_ZERO_NOBIN: begin
          if (neg_next && !signed_mode) e_st = ST_RANGE;
          else begin
            v = 64'd0; bad = 1'b1;
          end
        end
        PH_DIGITS: begin
          if (signed_mode) begin
            lim = neg_next ? SignBit : SignBit - 64'd1;
            if (ovf_next || acc_next > lim) begin
              e_val = lim; e_st = ST_RANGE;
            end else begin
              v = neg_next ? 64'd0 - acc_next : acc_next; bad = 1'b1;
            end
          end else if (neg_next) begin
            e_st = ST_RANGE;
          end else if (ovf_next) begin
            e_val = '1; e_st = ST_RANGE;
          end else begin
            v = acc_next; bad = 1'b1;
          end
        end
        PH_BIN: begin
          if (signed_mode && bits_next > 7'd63) e_st = ST_RANGE;
          else if (!signed_mode && neg_next) e_st = ST_RANGE;
          else begin
            v = neg_next ? 64'd0 - acc_next : acc_next; bad = 1'b1;
          end
        end
        PH_KEYWORD: begin
          if (kpos_next == 3'd3) e_val = range_high;
          else if (kpos_next == 3'd5) e_val = signed_mode ? range_low : 64'd0;
          else e_st = ST_MALFORMED;
        end
        default: e_st = ST_MALFORMED;
      endcase
      // bad here marks "range check pending"
      if (bad) begin
        e_val = v;
        if (signed_mode) e_st = (s_le(range_low, v) && s_le(v, range_high)) ? ST_OK : ST_RANGE;
        else e_st = (v > range_high) ? ST_RANGE : ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE; acc <= 64'd0; base <= BASE_DEC; neg <= 1'b0;
      ovf <= 1'b0; bits <= 7'd0; kpos <= 3'd0; count <= 8'd0;
      out_valid <= 1'b0;
    end else begin
      if (step) begin
        if (emit) begin
          phase <= PH_IDLE; acc <= 64'd0; base <= BASE_DEC; neg <= 1'b0;
          ovf <= 1'b0; bits <= 7'd0; kpos <= 3'd0; count <= 8'd0;
        end else begin
          phase <= phase_next; acc <= acc_next; base <= base_next; neg <= neg_next;
          ovf <= ovf_next; bits <= bits_next; kpos <= kpos_next; count <= count_next;
        end
      end
      if (step && emit) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      out_item.value    <= e_val;
      out_item.status   <= e_st;
      out_item.consumed <= e_cnt;
    end
  end
endmodule

/* hw/rtl/integer_literal_parser_core.sv */
// ----------------------------------------------------------------------------
// integer_literal_parser_core - streaming integer literal parser
// Parses one literal from a character stream and reports value and status.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall  | in_item (char_code, end_of_text)
//  out     | output    | out_valid/out_stall| out_item (value, status, consumed)
//  cfg     | input     | APB psel/penable   | signed_mode, range_low, range_high
//
// One character a cycle sustained while the output is not stalled. A character
// is staged in the front register, passes the four-entry queue and is stepped
// by the back end's parser, whose shift-add accumulator sets the rate, which
// then registers each result in the output register.
// Synchronous reset clears all control; registers return to their defaults.
// A stalled result holds in the output register; the queue absorbs input
// until full, then in_stall rises.
module integer_literal_parser_core #(
  parameter int unsigned MAX_TOKEN_CHARS = ilp_pkg::MaxTokenChars
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  ilp_pkg::in_item_t  in_item,
  output logic               in_stall,
  output logic               out_valid,
  output ilp_pkg::out_item_t out_item,
  input  logic               out_stall,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);
  import ilp_pkg::*;

  logic        signed_mode;
  logic [63:0] range_low;
  logic [63:0] range_high;
  logic        push, full, pop, not_empty;
  char_info_t  push_info, head;
  reg_index_t  reg_sel;

  // Registers sit at 8-byte spacing.
  assign reg_sel = reg_index_t'(paddr[4:3]);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      signed_mode <= 1'b1;
      range_low   <= SignBit;
      range_high  <= SignBit - 64'd1;
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        REG_SIGNED_MODE: signed_mode <= pwdata[0];
        REG_RANGE_LOW:   range_low   <= pwdata;
        REG_RANGE_HIGH:  range_high  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_SIGNED_MODE: prdata = {63'd0, signed_mode};
      REG_RANGE_LOW:   prdata = range_low;
      REG_RANGE_HIGH:  prdata = range_high;
      default:         prdata = 64'd0;
    endcase
  end

  ilp_front u_front (
    .clk, .rst, .in_valid, .in_item, .in_stall,
    .push, .push_info, .full
  );

  ilp_queue u_queue (
    .clk, .rst, .push, .push_info, .full, .pop, .not_empty, .head
  );

  ilp_back #(.MAX_TOKEN_CHARS(MAX_TOKEN_CHARS)) u_back (
    .clk, .rst, .not_empty, .head, .pop,
    .signed_mode, .range_low, .range_high,
    .out_valid, .out_item, .out_stall
  );
endmodule

/* dv/tb_integer_literal_parser_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_integer_literal_parser_core - self-checking bench for the literal parser
// Streams text characters through the parser and compares every result it
// emits against an in-bench model of the parse. The bench runs a directed
// token table first, then random token streams under several range settings
// and handshake pressure patterns.
// ----------------------------------------------------------------------------
module tb_integer_literal_parser_core;
  import ilp_pkg::*;

  localparam int unsigned CountCap = (MaxTokenChars < 255) ? MaxTokenChars : 255;
  localparam int unsigned RandItems = 1100;
  localparam int unsigned DrainCycles = 40;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  in_item_t           in_item = '0;
  logic               in_stall;
  logic               out_valid;
  out_item_t          out_item;
  logic               out_stall = 1'b0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [4:0]         paddr = '0;
  logic [63:0]        pwdata = '0;
  logic [63:0]        prdata;
  logic               pready;

  integer_literal_parser_core u_dut (
    .clk, .rst, .in_valid, .in_item, .in_stall, .out_valid, .out_item,
    .out_stall, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #4 clk = ~clk;

  // Hard stop in case the design hangs.
  initial begin
    #4_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Parse model: register copies plus the token state.
  // --------------------------------------------------------------------------
  logic        mode_signed = 1'b1;
  logic [63:0] lim_low  = SignBit;
  logic [63:0] lim_high = SignBit - 64'd1;

  phase_t      tok_phase = PH_IDLE;
  logic [63:0] tok_acc = '0;
  base_t       tok_base = BASE_DEC;
  logic        tok_neg = 1'b0;
  logic        tok_ovf = 1'b0;
  int unsigned tok_bits = 0;
  int unsigned tok_kpos = 0;
  int unsigned tok_count = 0;

  out_item_t   expected_results[$];
  int unsigned mismatch_count = 0;

  // Percent chances of an idle cycle on each side for the current phase.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  function automatic bit is_space(logic [7:0] c);
    return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic bit is_alnum(logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic [7:0] lower_of(logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function automatic int unsigned digit_value(logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return 16;
  endfunction

  // Signed less-or-equal on raw 64-bit values.
  function automatic bit signed_le(logic [63:0] a, logic [63:0] b);
    return (a ^ SignBit) <= (b ^ SignBit);
  endfunction

  function automatic void clear_token();
    tok_phase = PH_IDLE;
    tok_acc   = '0;
    tok_base  = BASE_DEC;
    tok_neg   = 1'b0;
    tok_ovf   = 1'b0;
    tok_bits  = 0;
    tok_kpos  = 0;
    tok_count = 0;
  endfunction

  function automatic void count_char();
    if (tok_count < CountCap) tok_count++;
  endfunction

  function automatic out_item_t make_result(logic [63:0] v, status_t st);
    out_item_t r;
    r.value    = v;
    r.status   = st;
    r.consumed = tok_count[7:0];
    clear_token();
    return r;
  endfunction

  function automatic out_item_t range_result(logic [63:0] v);
    bit bad;
    if (mode_signed) bad = !(signed_le(lim_low, v) && signed_le(v, lim_high));
    else bad = v > lim_high;
    return make_result(v, bad ? ST_RANGE : ST_OK);
  endfunction

  // Close the current token and form its result.
  function automatic out_item_t close_token();
    logic [63:0] sat;
    case (tok_phase)
      PH_ZERO, PH_ZERO_NOBIN: begin
        if (tok_neg && !mode_signed) return make_result('0, ST_RANGE);
        return range_result('0);
      end
      PH_DIGITS: begin
        if (mode_signed) begin
          sat = tok_neg ? SignBit : SignBit - 64'd1;
          if (tok_ovf || tok_acc > sat) return make_result(sat, ST_RANGE);
          return range_result(tok_neg ? -tok_acc : tok_acc);
        end
        if (tok_neg) return make_result('0, ST_RANGE);
        if (tok_ovf) return make_result('1, ST_RANGE);
        return range_result(tok_acc);
      end
      PH_BIN: begin
        if (mode_signed) begin
          if (tok_bits > 63) return make_result('0, ST_RANGE);
          return range_result(tok_neg ? -tok_acc : tok_acc);
        end
        if (tok_neg) return make_result('0, ST_RANGE);
        return range_result(tok_acc);
      end
      PH_KEYWORD: begin
        if (tok_kpos == 3) return make_result(lim_high, ST_OK);
        if (tok_kpos == 5) return make_result(mode_signed ? lim_low : '0, ST_OK);
        return make_result('0, ST_MALFORMED);
      end
      default: return make_result('0, ST_MALFORMED);
    endcase
  endfunction

  // Advance the parse by one character; returns 1 when a result is due.
  function automatic bit parse_char(in_item_t it, output out_item_t r);
    logic [7:0]  c;
    logic [7:0]  lc;
    bit          eot;
    int unsigned d;
    int unsigned b;
    int unsigned wlen;
    logic [7:0]  want;
    c   = it.char_code;
    eot = it.end_of_text;
    r   = '0;
    case (tok_phase)
      PH_IDLE: begin
        if (is_space(c)) begin
          count_char();
          if (eot) begin
            r = make_result('0, ST_MALFORMED);
            return 1;
          end
          return 0;
        end
        if (c == "-" && !mode_signed) begin
          r = make_result('0, ST_RANGE);
          return 1;
        end
        if (c == "t") begin
          tok_phase = PH_TRUE; tok_kpos = 1;
        end else if (c == "f") begin
          tok_phase = PH_FALSE; tok_kpos = 1;
        end else if (lower_of(c) == "m") begin
          tok_phase = PH_KEYWORD; tok_kpos = 1;
        end else if (c == "-") begin
          tok_phase = PH_MINUS; tok_neg = 1'b1;
        end else if (c == "+") begin
          tok_phase = PH_PLUS;
        end else if (c == "0") begin
          tok_phase = PH_ZERO;
        end else if (c >= "1" && c <= "9") begin
          tok_phase = PH_DIGITS; tok_base = BASE_DEC; tok_acc = 64'(c - "0");
        end else begin
          r = make_result('0, ST_MALFORMED);
          return 1;
        end
      end
      PH_TRUE, PH_FALSE: begin
        wlen = (tok_phase == PH_TRUE) ? 4 : 5;
        case (tok_kpos)
          1: want = (tok_phase == PH_TRUE) ? "r" : "a";
          2: want = (tok_phase == PH_TRUE) ? "u" : "l";
          3: want = (tok_phase == PH_TRUE) ? "e" : "s";
          4: want = "e";
          default: want = 8'd0;
        endcase
        if (tok_kpos >= wlen || c != want) begin
          r = make_result('0, ST_MALFORMED);
          return 1;
        end
        tok_kpos++;
        count_char();
        if (tok_kpos == wlen) begin
          r = make_result((tok_phase == PH_TRUE) ? 64'd1 : 64'd0, ST_OK);
          return 1;
        end
        if (eot) begin
          r = make_result('0, ST_MALFORMED);
          return 1;
        end
        return 0;
      end
      PH_KEYWORD: begin
        if (tok_kpos == 3 || tok_kpos == 5) begin
          if (is_alnum(c)) r = make_result('0, ST_MALFORMED);
          else r = close_token();
          return 1;
        end
        lc = lower_of(c);
        if (tok_kpos == 1 && lc == "a") tok_kpos = 2;
        else if (tok_kpos == 1 && lc == "i") tok_kpos = 4;
        else if (tok_kpos == 2 && lc == "x") tok_kpos = 3;
        else if (tok_kpos == 4 && lc == "n") tok_kpos = 5;
        else begin
          r = make_result('0, ST_MALFORMED);
          return 1;
        end
      end
      PH_MINUS, PH_PLUS: begin
        if (c == "0") begin
          tok_phase = (tok_phase == PH_MINUS) ? PH_ZERO : PH_ZERO_NOBIN;
        end else if (c >= "1" && c <= "9") begin
          tok_phase = PH_DIGITS; tok_base = BASE_DEC; tok_acc = 64'(c - "0");
        end else begin
          r = make_result('0, ST_MALFORMED);
          return 1;
        end
      end
      PH_ZERO, PH_ZERO_NOBIN: begin
        if (c == "b" && tok_phase == PH_ZERO) begin
          tok_phase = PH_BIN; tok_base = BASE_BIN;
        end else if (c == "x" || c == "X") begin
          tok_phase = PH_HEXPFX;
        end else if (c >= "0" && c <= "7") begin
          tok_phase = PH_DIGITS; tok_base = BASE_OCT; tok_acc = 64'(c - "0");
        end else begin
          r = close_token();
          return 1;
        end
      end
      PH_HEXPFX: begin
        d = digit_value(c);
        if (d >= 16) begin
          r = make_result('0, ST_MALFORMED);
          return 1;
        end
        tok_phase = PH_DIGITS; tok_base = BASE_HEX; tok_acc = 64'(d);
      end
      PH_DIGITS: begin
        b = (tok_base == BASE_OCT) ? 8 : (tok_base == BASE_HEX) ? 16 : 10;
        d = digit_value(c);
        if (d >= b) begin
          r = close_token();
          return 1;
        end
        if (!tok_ovf) begin
          if (tok_acc > (64'hFFFF_FFFF_FFFF_FFFF - 64'(d)) / 64'(b)) tok_ovf = 1'b1;
          else tok_acc = tok_acc * 64'(b) + 64'(d);
        end
      end
      PH_BIN: begin
        if (c == "0") begin
          if (tok_bits != 0) begin
            tok_acc = tok_acc << 1; tok_bits++;
          end
        end else if (c == "1") begin
          tok_acc = (tok_acc << 1) | 64'd1;
          tok_bits++;
        end else begin
          r = close_token();
          return 1;
        end
        if (tok_bits > (mode_signed ? 63 : 64)) begin
          r = make_result('0, ST_RANGE);
          return 1;
        end
      end
      default: begin
        clear_token();
        return 0;
      end
    endcase
    count_char();
    if (eot) begin
      r = close_token();
      return 1;
    end
    return 0;
  endfunction

  // --------------------------------------------------------------------------
  // Result side: random stall, compare each transfer with the oldest entry.
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", out_item.value, '0);
        end else begin
          want = expected_results.pop_front();
          if (out_item.value !== want.value)
            report_mismatch("value", out_item.value, want.value);
          if (out_item.status !== want.status)
            report_mismatch("status", 64'(out_item.status), 64'(want.status));
          if (out_item.consumed !== want.consumed)
            report_mismatch("consumed", 64'(out_item.consumed), 64'(want.consumed));
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Character side.
  // --------------------------------------------------------------------------
  // Send one character; optionally swap the model's result for a typed one.
  task automatic send_char(input in_item_t it, input bit use_typed,
                           input out_item_t typed);
    out_item_t r;
    bit        due;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // Transfer taken at this edge: step the model now.
    due = parse_char(it, r);
    if (due) expected_results.push_back(use_typed ? typed : r);
  endtask

  task automatic send_text(input string s, input bit eot_last, input bit use_typed,
                           input out_item_t typed);
    in_item_t it;
    for (int i = 0; i < s.len(); i++) begin
      it.char_code   = s[i];
      it.end_of_text = eot_last && (i == s.len() - 1);
      send_char(it, use_typed && (i == s.len() - 1), typed);
    end
  endtask

  // Write one register over APB and update the model's copy of it.
  task automatic reg_write(input reg_index_t idx, input logic [63:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 5'(idx) << 3;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_SIGNED_MODE: mode_signed = data[0];
      REG_RANGE_LOW:   lim_low = data;
      default:         lim_high = data;
    endcase
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Random token builder: mostly well-formed literals, some noise.
  function automatic byte rand_ws();
    int unsigned k;
    k = $urandom_range(6);
    return (k == 6) ? 8'd32 : 8'(9 + k % 5);
  endfunction

  function automatic void build_token(ref byte q[$]);
    string       boundary[6];
    int unsigned kind;
    int unsigned n;
    string       s;
    boundary = '{"9223372036854775807", "9223372036854775808", "18446744073709551615",
                 "18446744073709551616", "99999999999999999999", "1"};
    repeat ($urandom_range(2)) q.push_back(rand_ws());
    kind = $urandom_range(9);
    case (kind)
      0: begin
        s = $urandom_range(1) ? "true" : "false";
        n = ($urandom_range(3) == 0) ? $urandom_range(1, s.len()) : s.len();
        for (int i = 0; i < n; i++) q.push_back(s[i]);
      end
      1: begin
        s = $urandom_range(1) ? "max" : "min";
        for (int i = 0; i < 3; i++) q.push_back($urandom_range(1) ? s[i] : s[i] - 8'd32);
        if ($urandom_range(4) == 0) q.push_back("7");
      end
      2, 7: begin
        if ($urandom_range(2) == 0) q.push_back($urandom_range(1) ? "-" : "+");
        if (kind == 7) begin
          s = boundary[$urandom_range(5)];
          for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
        end else begin
          q.push_back(8'("1") + 8'($urandom_range(8)));
          repeat ($urandom_range(21)) q.push_back(8'("0") + 8'($urandom_range(9)));
        end
      end
      3: begin
        if ($urandom_range(3) == 0) q.push_back("-");
        q.push_back("0");
        q.push_back($urandom_range(1) ? "x" : "X");
        repeat ($urandom_range(18)) begin
          n = $urandom_range(15);
          q.push_back(n < 10 ? 8'("0") + 8'(n) :
                      ($urandom_range(1) ? 8'("a") : 8'("A")) + 8'(n - 10));
        end
      end
      4: begin
        if ($urandom_range(3) == 0) q.push_back($urandom_range(1) ? "-" : "+");
        q.push_back("0");
        repeat ($urandom_range(23)) q.push_back(8'("0") + 8'($urandom_range(7)));
      end
      5, 8: begin
        if ($urandom_range(2) == 0) q.push_back($urandom_range(3) == 0 ? "+" : "-");
        q.push_back("0");
        q.push_back("b");
        repeat ($urandom_range(3)) q.push_back("0");
        n = ($urandom_range(2) == 0) ? $urandom_range(60, 66) : $urandom_range(40);
        repeat (n) q.push_back($urandom_range(1) ? "1" : "0");
      end
      default: begin
        repeat ($urandom_range(1, 3)) q.push_back(8'($urandom_range(255)));
      end
    endcase
    // Terminator: a separator, a random byte, or nothing.
    case ($urandom_range(3))
      0: q.push_back(" ");
      1: q.push_back(",");
      2: q.push_back(8'($urandom_range(255)));
      default: ;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Directed token table (reset configuration: signed, full range).
  // --------------------------------------------------------------------------
  typedef struct {
    string     text;
    bit        eot_last;
    bit        typed;
    out_item_t want;
  } token_row_t;

  localparam logic [63:0] MaxS = 64'h7FFF_FFFF_FFFF_FFFF;

  token_row_t token_table[] = '{
    '{"true",  1'b0, 1'b1, '{64'd1, ST_OK, 8'd4}},
    '{"false", 1'b0, 1'b1, '{64'd0, ST_OK, 8'd5}},
    '{"  max ", 1'b0, 1'b1, '{MaxS, ST_OK, 8'd5}},
    '{"MiN;", 1'b0, 1'b1, '{SignBit, ST_OK, 8'd3}},
    '{"maxa", 1'b0, 1'b1, '{64'd0, ST_MALFORMED, 8'd3}},
    '{"0x;", 1'b0, 1'b1, '{64'd0, ST_MALFORMED, 8'd2}},
    '{"+0b", 1'b0, 1'b1, '{64'd0, ST_OK, 8'd2}},
    '{"9223372036854775808 ", 1'b0, 1'b1, '{MaxS, ST_RANGE, 8'd19}},
    '{"-9223372036854775808 ", 1'b0, 1'b0, '{64'd0, ST_OK, 8'd0}},
    '{"-9223372036854775809 ", 1'b0, 1'b1, '{SignBit, ST_RANGE, 8'd20}},
    '{"0x7FFFffffFFFFffff,", 1'b0, 1'b0, '{64'd0, ST_OK, 8'd0}},
    '{"0777 ", 1'b0, 1'b0, '{64'd0, ST_OK, 8'd0}},
    '{"-0b101 ", 1'b0, 1'b0, '{64'd0, ST_OK, 8'd0}},
    '{"0b1111111111111111111111111111111111111111111111111111111111111111", 1'b0,
      1'b1, '{64'd0, ST_RANGE, 8'd65}},
    '{"   ", 1'b1, 1'b1, '{64'd0, ST_MALFORMED, 8'd3}},
    '{"@", 1'b0, 1'b1, '{64'd0, ST_MALFORMED, 8'd0}},
    '{"\377", 1'b0, 1'b1, '{64'd0, ST_MALFORMED, 8'd0}},
    '{"12", 1'b1, 1'b0, '{64'd0, ST_OK, 8'd0}},
    '{"\t0", 1'b1, 1'b0, '{64'd0, ST_OK, 8'd0}}
  };

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    byte         chars[$];
    in_item_t    it;
    int unsigned sent;
    int unsigned phase_items;
    logic [63:0] lo;
    logic [63:0] hi;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows run with no idling on either side.
    foreach (token_table[i])
      send_text(token_table[i].text, token_table[i].eot_last, token_table[i].typed,
                token_table[i].want);
    settle();

    // Random phases: rotate idle patterns, change registers between phases.
    sent = 0;
    for (int ph = 0; sent < RandItems; ph++) begin
      case (ph % 6)
        0: begin lo = 64'd0;          hi = '1;            end
        1: begin lo = -64'sd1000;     hi = 64'd1000;      end
        2: begin lo = SignBit;        hi = MaxS;          end
        3: begin lo = MaxS;           hi = MaxS;          end
        4: begin lo = 64'($urandom) << 20; hi = {$urandom, $urandom}; end
        default: begin lo = SignBit;  hi = 64'd0;         end
      endcase
      reg_write(REG_SIGNED_MODE, 64'(ph % 3 != 0));
      reg_write(REG_RANGE_LOW, lo);
      reg_write(REG_RANGE_HIGH, hi);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
        default: begin send_idle_pct = 24; recv_stall_pct = 24; end
      endcase
      phase_items = 0;
      while (phase_items < 140) begin
        chars.delete();
        build_token(chars);
        // Mark the last character of a token as end of text one time in four.
        foreach (chars[k]) begin
          it.char_code   = chars[k];
          it.end_of_text = (k == chars.size() - 1) && ($urandom_range(3) == 0);
          send_char(it, 1'b0, '0);
        end
        phase_items += chars.size();
      end
      sent += phase_items;
      settle();
    end

    // Settle with no stall, then flag anything left waiting.
    recv_stall_pct = 0;
    settle();
    if (expected_results.size() != 0)
      report_mismatch("missing results", 64'(expected_results.size()), '0);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
